[hw/rtl/qara_pkg.sv]
// Shared types, constants and tables for the quaternion axis rotation accumulator.
// Holds the operation codes, the CORDIC arctangent table and the rotation pairing rules.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package qara_pkg;

	// Default widths and iteration count of the block.
	localparam int unsigned COMPONENT_BITS_DEF = 16;
	localparam int unsigned ANGLE_BITS_DEF     = 16;
	localparam int unsigned CORDIC_STEPS_DEF   = 14;

	// Depth of the queue between the angle front end and the quaternion back end.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Sine and cosine are Q.30 values that stay inside 32 signed bits.
	localparam int unsigned TRIG_W     = 32;
	// The CORDIC residual angle gets one guard bit above Q.30.
	localparam int unsigned ZW         = 33;
	localparam int unsigned FRAC_SHIFT = 30;

	localparam logic signed [33:0]       PI_Q30   = 34'sd3373259426;
	localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [TRIG_W-1:0] HALF_Q30 = 32'sd536870912;

	// Input mode codes.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_ROTATE = 1'b1;

	// Axis codes; the fourth code selects no rotation.
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	// Quaternion component indexes.
	localparam logic [1:0] CMP_X = 2'd0;
	localparam logic [1:0] CMP_Y = 2'd1;
	localparam logic [1:0] CMP_Z = 2'd2;
	localparam logic [1:0] CMP_W = 2'd3;

	// What the back end does with an item.
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ROT  = 2'd1,
		OP_KEEP = 2'd2
	} op_t;

	// Control part of an item as it travels from the front end to the back end.
	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} ctl_t;

	// Second operand of a component update: the partner component and whether
	// its sine product is subtracted.
	typedef struct packed {
		logic [1:0] idx;
		logic       neg;
	} pair_t;

	// Arctangent of 2^-i in Q.30.
	function automatic logic [TRIG_W-1:0] atan_q30(input int unsigned i);
		logic [TRIG_W-1:0] v;
		unique case (i)
			0:       v = 32'h3243F6A8;
			1:       v = 32'h1DAC6705;
			2:       v = 32'h0FADBAFC;
			3:       v = 32'h07F56EA6;
			4:       v = 32'h03FEAB76;
			5:       v = 32'h01FFD55B;
			6:       v = 32'h00FFFAAA;
			7:       v = 32'h007FFF55;
			8:       v = 32'h003FFFEA;
			9:       v = 32'h001FFFFD;
			10:      v = 32'h000FFFFF;
			11:      v = 32'h0007FFFF;
			12:      v = 32'h0003FFFF;
			13:      v = 32'h0001FFFF;
			14:      v = 32'h0000FFFF;
			15:      v = 32'h00007FFF;
			16:      v = 32'h00003FFF;
			17:      v = 32'h00001FFF;
			18:      v = 32'h00000FFF;
			19:      v = 32'h000007FF;
			20:      v = 32'h000003FF;
			21:      v = 32'h000001FF;
			22:      v = 32'h000000FF;
			23:      v = 32'h0000007F;
			24:      v = 32'h0000003F;
			25:      v = 32'h0000001F;
			26:      v = 32'h0000000F;
			27:      v = 32'h00000008;
			28:      v = 32'h00000004;
			29:      v = 32'h00000002;
			30:      v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// New component k = c * q[k] +/- s * q[partner], for a rotation about the given axis.
	function automatic pair_t pair(input logic [1:0] axis, input logic [1:0] k);
		pair_t p;
		p = '{idx: CMP_W, neg: 1'b0};
		unique case (axis)
			AXIS_X: begin
				unique case (k)
					CMP_X:   p = '{idx: CMP_W, neg: 1'b0};
					CMP_Y:   p = '{idx: CMP_Z, neg: 1'b1};
					CMP_Z:   p = '{idx: CMP_Y, neg: 1'b0};
					default: p = '{idx: CMP_X, neg: 1'b1};
				endcase
			end
			AXIS_Y: begin
				unique case (k)
					CMP_X:   p = '{idx: CMP_Z, neg: 1'b0};
					CMP_Y:   p = '{idx: CMP_W, neg: 1'b0};
					CMP_Z:   p = '{idx: CMP_X, neg: 1'b1};
					default: p = '{idx: CMP_Y, neg: 1'b1};
				endcase
			end
			default: begin
				unique case (k)
					CMP_X:   p = '{idx: CMP_Y, neg: 1'b1};
					CMP_Y:   p = '{idx: CMP_X, neg: 1'b0};
					CMP_Z:   p = '{idx: CMP_W, neg: 1'b0};
					default: p = '{idx: CMP_Z, neg: 1'b1};
				endcase
			end
		endcase
		return p;
	endfunction

endpackage

[hw/rtl/qara_if.sv]
// Valid/ready channel interfaces of the quaternion axis rotation accumulator.
// qara_cmd_if carries input items, qara_res_if carries result items.
// Depends on qara_pkg for default widths.
`timescale 1ns / 1ps

interface qara_cmd_if #(
	parameter int unsigned COMPONENT_BITS = qara_pkg::COMPONENT_BITS_DEF,
	parameter int unsigned ANGLE_BITS     = qara_pkg::ANGLE_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [1:0]                       axis;
	logic signed [ANGLE_BITS-1:0]     angle;
	logic signed [COMPONENT_BITS-1:0] load_x;
	logic signed [COMPONENT_BITS-1:0] load_y;
	logic signed [COMPONENT_BITS-1:0] load_z;
	logic signed [COMPONENT_BITS-1:0] load_w;

	modport source (
		output valid, mode, axis, angle, load_x, load_y, load_z, load_w,
		input  ready
	);
	modport sink (
		input  valid, mode, axis, angle, load_x, load_y, load_z, load_w,
		output ready
	);
endinterface

interface qara_res_if #(
	parameter int unsigned COMPONENT_BITS = qara_pkg::COMPONENT_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] out_x;
	logic signed [COMPONENT_BITS-1:0] out_y;
	logic signed [COMPONENT_BITS-1:0] out_z;
	logic signed [COMPONENT_BITS-1:0] out_w;
	logic                             saturated;

	modport source (
		output valid, out_x, out_y, out_z, out_w, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_w, saturated,
		output ready
	);
endinterface

[hw/rtl/qara_front.sv]
// Front end: accepts items, classifies them and runs the half-angle CORDIC pipeline.
// One CORDIC iteration per stage; the pipeline stalls while a finished item waits on a full queue.
// Depends on qara_pkg and qara_cmd_if.
`timescale 1ns / 1ps

module qara_front #(
	parameter int unsigned COMPONENT_BITS = qara_pkg::COMPONENT_BITS_DEF,
	parameter int unsigned ANGLE_BITS     = qara_pkg::ANGLE_BITS_DEF,
	parameter int unsigned CORDIC_STEPS   = qara_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	qara_cmd_if.sink                             cmd,
	input  logic                                 q_full,
	output logic                                 push,
	output qara_pkg::ctl_t                       ctl,
	output logic signed [qara_pkg::TRIG_W-1:0]   sin_h,
	output logic signed [qara_pkg::TRIG_W-1:0]   cos_h,
	output logic [4*COMPONENT_BITS-1:0]          ld
);
	localparam int unsigned TW  = qara_pkg::TRIG_W;
	localparam int unsigned ZW  = qara_pkg::ZW;
	localparam int unsigned HPW = ANGLE_BITS + 34;
	localparam int unsigned N   = CORDIC_STEPS;

	logic [N:0]                          v_s;
	qara_pkg::ctl_t                      ctl_s [N+1];
	logic [4*COMPONENT_BITS-1:0]         ld_s  [N+1];
	logic signed [TW-1:0]                x_s   [N+1];
	logic signed [TW-1:0]                y_s   [N+1];
	logic signed [ZW-1:0]                z_s   [N+1];
	logic signed [HPW-1:0]               hprod;
	logic                                adv;
	qara_pkg::ctl_t                      ctl_in;

	// The pipeline moves unless a finished item is blocked by a full queue.
	assign adv       = !v_s[N] || !q_full;
	assign cmd.ready = adv;
	assign push      = v_s[N] && !q_full;

	// Classify the item for the back end.
	always_comb begin
		ctl_in.axis = cmd.axis;
		if (cmd.mode == qara_pkg::MODE_LOAD) begin
			ctl_in.op = qara_pkg::OP_LOAD;
		end else if (cmd.axis == qara_pkg::AXIS_NONE) begin
			ctl_in.op = qara_pkg::OP_KEEP;
		end else begin
			ctl_in.op = qara_pkg::OP_ROT;
		end
	end

	// Half angle in Q.30 radians: angle * pi / 2^ANGLE_BITS, floored.
	assign hprod = HPW'(cmd.angle) * HPW'(qara_pkg::PI_Q30);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[N-1:0], cmd.valid};
		end
	end

	// Stage zero: classified item, starting CORDIC vector and half angle.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= ctl_in;
			ld_s[0]  <= {cmd.load_x, cmd.load_y, cmd.load_z, cmd.load_w};
			x_s[0]   <= qara_pkg::GAIN_Q30;
			y_s[0]   <= '0;
			z_s[0]   <= hprod[ANGLE_BITS+ZW-1:ANGLE_BITS];
		end
	end

	// One rotation-mode CORDIC iteration per stage.
	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [TW-1:0] dx;
		logic signed [TW-1:0] dy;
		logic signed [ZW-1:0] at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed(ZW'(qara_pkg::atan_q30(i)));

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[i+1] <= ctl_s[i];
				ld_s[i+1]  <= ld_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	assign ctl   = ctl_s[N];
	assign ld    = ld_s[N];
	assign cos_h = x_s[N];
	assign sin_h = y_s[N];

endmodule

[hw/rtl/qara_queue.sv]
// Short first-in first-out queue between the front end and the back end.
// Register storage with a head read; push is ignored when full, pop when empty.
// Depends on qara_pkg for the default depth.
`timescale 1ns / 1ps

module qara_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = qara_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/qara_back.sv]
// Back end: holds the orientation quaternion and applies loads and axis rotations.
// A rotation computes two components per cycle on four multipliers, then rounds
// and clamps them; results go to a registered output stage. Depends on qara_pkg.
`timescale 1ns / 1ps

module qara_back #(
	parameter int unsigned COMPONENT_BITS = qara_pkg::COMPONENT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               hd_valid,
	input  qara_pkg::ctl_t                     hd_ctl,
	input  logic signed [qara_pkg::TRIG_W-1:0] hd_sin,
	input  logic signed [qara_pkg::TRIG_W-1:0] hd_cos,
	input  logic [4*COMPONENT_BITS-1:0]        hd_ld,
	output logic                               pop,
	qara_res_if.source                         res
);
	localparam int unsigned CW = COMPONENT_BITS;
	localparam int unsigned TW = qara_pkg::TRIG_W;
	localparam int unsigned PW = TW + CW;
	localparam int unsigned SW = PW + 1;
	localparam int unsigned RW = SW - qara_pkg::FRAC_SHIFT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic signed [CW-1:0]  st_q   [4];
	logic signed [CW-1:0]  old_q  [4];
	logic signed [CW-1:0]  src    [4];
	logic signed [CW-1:0]  ldv    [4];
	logic signed [CW-1:0]  out_q  [4];
	logic                  sat_out_q;
	logic                  res_valid_q;
	logic                  sat_acc_q;
	logic signed [TW-1:0]  s_q;
	logic signed [TW-1:0]  c_q;
	logic [1:0]            axis_q;
	logic signed [PW-1:0]  pc_s1  [2];
	logic signed [PW-1:0]  ps_s1  [2];
	logic                  neg_s1 [2];
	logic signed [CW-1:0]  fin    [2];
	logic                  fin_sat[2];
	logic                  busy;
	logic                  out_free;
	logic                  start_rot;
	logic                  res_set;
	logic [1:0]            ax;
	logic signed [TW-1:0]  cs;
	logic signed [TW-1:0]  sn;

	// Four-way pick among quaternion components.
	function automatic logic signed [CW-1:0] pick(
		input logic [1:0]           i,
		input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b,
		input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] d
	);
		logic signed [CW-1:0] r;
		unique case (i)
			qara_pkg::CMP_X: r = a;
			qara_pkg::CMP_Y: r = b;
			qara_pkg::CMP_Z: r = c;
			default:         r = d;
		endcase
		return r;
	endfunction

	// Handshake-level control.
	assign busy      = (state_q == ST_MUL1);
	assign out_free  = !res_valid_q || res.ready;
	assign start_rot = (state_q == ST_IDLE) && hd_valid && (hd_ctl.op == qara_pkg::OP_ROT);
	assign pop       = (state_q == ST_IDLE) && hd_valid
	                   && ((hd_ctl.op == qara_pkg::OP_ROT) || out_free);

	// A new result enters the output register this cycle.
	assign res_set   = out_free && ((state_q == ST_FIN)
	                   || ((state_q == ST_IDLE) && hd_valid
	                       && ((hd_ctl.op == qara_pkg::OP_LOAD)
	                           || (hd_ctl.op == qara_pkg::OP_KEEP))));

	// Operands come from the live state at the start, from the snapshot afterwards.
	assign ax = busy ? axis_q : hd_ctl.axis;
	assign cs = busy ? c_q : hd_cos;
	assign sn = busy ? s_q : hd_sin;

	for (genvar k = 0; k < 4; k++) begin : g_comp
		assign src[k] = busy ? old_q[k] : st_q[k];
		assign ldv[k] = $signed(hd_ld[(3-k)*CW +: CW]);
	end

	// Two product lanes; lane j serves component j first and component j+2 next.
	for (genvar j = 0; j < 2; j++) begin : g_lane
		logic [1:0]            kk;
		qara_pkg::pair_t       pr;
		logic signed [CW-1:0]  qa;
		logic signed [CW-1:0]  qb;
		logic signed [SW-1:0]  sum;
		logic [RW-1:0]         r;
		logic [RW-CW:0]        top;

		assign kk = busy ? 2'(j + 2) : 2'(j);
		assign pr = qara_pkg::pair(ax, kk);
		assign qa = pick(kk, src[0], src[1], src[2], src[3]);
		assign qb = pick(pr.idx, src[0], src[1], src[2], src[3]);

		always_ff @(posedge clk) begin
			if (start_rot || busy) begin
				pc_s1[j]  <= PW'(cs) * PW'(qa);
				ps_s1[j]  <= PW'(sn) * PW'(qb);
				neg_s1[j] <= pr.neg;
			end
		end

		// Round to nearest (half up) at bit 30, then clamp to the component range.
		always_comb begin
			if (neg_s1[j]) begin
				sum = SW'(pc_s1[j]) - SW'(ps_s1[j]) + SW'(qara_pkg::HALF_Q30);
			end else begin
				sum = SW'(pc_s1[j]) + SW'(ps_s1[j]) + SW'(qara_pkg::HALF_Q30);
			end
			r   = sum[SW-1:qara_pkg::FRAC_SHIFT];
			top = r[RW-1:CW-1];
			if ((&top) || !(|top)) begin
				fin[j]     = r[CW-1:0];
				fin_sat[j] = 1'b0;
			end else begin
				fin[j]     = r[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
				fin_sat[j] = 1'b1;
			end
		end
	end

	// Snapshot of the rotation's inputs.
	always_ff @(posedge clk) begin
		if (start_rot) begin
			for (int k = 0; k < 4; k++) begin
				old_q[k] <= st_q[k];
			end
			s_q    <= hd_sin;
			c_q    <= hd_cos;
			axis_q <= hd_ctl.axis;
		end
	end

	// Sequencer, orientation state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			st_q[0]     <= '0;
			st_q[1]     <= '0;
			st_q[2]     <= '0;
			st_q[3]     <= CW'(1) <<< (CW - 2);
			res_valid_q <= 1'b0;
			sat_acc_q   <= 1'b0;
			sat_out_q   <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				out_q[k] <= '0;
			end
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (hd_valid) begin
						unique case (hd_ctl.op)
							qara_pkg::OP_LOAD: begin
								if (out_free) begin
									for (int k = 0; k < 4; k++) begin
										st_q[k]  <= ldv[k];
										out_q[k] <= ldv[k];
									end
									sat_out_q <= 1'b0;
								end
							end
							qara_pkg::OP_KEEP: begin
								if (out_free) begin
									for (int k = 0; k < 4; k++) begin
										out_q[k] <= st_q[k];
									end
									sat_out_q <= 1'b0;
								end
							end
							qara_pkg::OP_ROT: begin
								state_q <= ST_MUL1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL1: begin
					st_q[0]   <= fin[0];
					st_q[1]   <= fin[1];
					sat_acc_q <= fin_sat[0] | fin_sat[1];
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						st_q[2]   <= fin[0];
						st_q[3]   <= fin[1];
						out_q[0]  <= st_q[0];
						out_q[1]  <= st_q[1];
						out_q[2]  <= fin[0];
						out_q[3]  <= fin[1];
						sat_out_q <= sat_acc_q | fin_sat[0] | fin_sat[1];
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid     = res_valid_q;
	assign res.out_x     = out_q[0];
	assign res.out_y     = out_q[1];
	assign res.out_z     = out_q[2];
	assign res.out_w     = out_q[3];
	assign res.saturated = sat_out_q;

endmodule

[hw/rtl/quaternion_axis_rotation_accumulator_top.sv]
// Quaternion axis rotation accumulator: keeps one Q2.14 orientation quaternion.
// Input channel cmd (valid/ready): mode 0 loads load_x..load_w, mode 1 rotates the
// stored quaternion about axis X, Y or Z by angle (pi/2^(ANGLE_BITS-1) rad units);
// axis code three leaves it unchanged. Output channel res returns the updated
// quaternion and a saturated flag for every item, in order.
// Throughput: one item per cycle for loads while res.ready is high and no
// rotation is under way. A rotation holds the back end in ST_MUL1 and then
// ST_FIN and takes no new item until it is finished; the rotation loop (two
// components per cycle on four multipliers, state written back before the next
// item reads it) sets that limit.
// The front end holds one item per CORDIC stage and a two-entry queue sits before
// the back end; cmd.ready stays high while a result waits, until the queue fills.
// Reset clears the valid bit of every pipeline stage, empties the queue and sets
// the state to the identity quaternion. When res.ready is low the result register
// holds, the back end stops, the queue fills and then the front pipeline stalls.
`timescale 1ns / 1ps

module quaternion_axis_rotation_accumulator_top #(
	parameter int unsigned COMPONENT_BITS = qara_pkg::COMPONENT_BITS_DEF,
	parameter int unsigned ANGLE_BITS     = qara_pkg::ANGLE_BITS_DEF,
	parameter int unsigned CORDIC_STEPS   = qara_pkg::CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qara_cmd_if.sink   cmd,
	qara_res_if.source res
);
	localparam int unsigned TW    = qara_pkg::TRIG_W;
	localparam int unsigned CTL_W = $bits(qara_pkg::ctl_t);
	localparam int unsigned LDW   = 4 * COMPONENT_BITS;
	localparam int unsigned QW    = CTL_W + 2 * TW + LDW;

	logic                 f_push;
	qara_pkg::ctl_t       f_ctl;
	logic signed [TW-1:0] f_sin;
	logic signed [TW-1:0] f_cos;
	logic [LDW-1:0]       f_ld;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;
	logic [QW-1:0]        q_rdata;
	qara_pkg::ctl_t       hd_ctl;
	logic signed [TW-1:0] hd_sin;
	logic signed [TW-1:0] hd_cos;
	logic [LDW-1:0]       hd_ld;

	// Accept, classify and compute the half-angle sine and cosine.
	qara_front #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.ANGLE_BITS     (ANGLE_BITS),
		.CORDIC_STEPS   (CORDIC_STEPS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_full (q_full),
		.push   (f_push),
		.ctl    (f_ctl),
		.sin_h  (f_sin),
		.cos_h  (f_cos),
		.ld     (f_ld)
	);

	// Decouple the front pipeline from the back end.
	qara_queue #(
		.WIDTH (QW),
		.DEPTH (qara_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_ctl, f_sin, f_cos, f_ld}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// Split the queue head into its fields.
	assign hd_ctl = qara_pkg::ctl_t'(q_rdata[QW-1 -: CTL_W]);
	assign hd_sin = $signed(q_rdata[QW-CTL_W-1 -: TW]);
	assign hd_cos = $signed(q_rdata[QW-CTL_W-TW-1 -: TW]);
	assign hd_ld  = q_rdata[LDW-1:0];

	// Apply the item to the orientation state and present the result.
	qara_back #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (q_valid),
		.hd_ctl   (hd_ctl),
		.hd_sin   (hd_sin),
		.hd_cos   (hd_cos),
		.hd_ld    (hd_ld),
		.pop      (q_pop),
		.res      (res)
	);

endmodule

[tb/quaternion_axis_rotation_accumulator_top_tb.sv]
// Self-checking testbench for the quaternion axis rotation accumulator.
// Drives load and rotate items with random gaps, predicts each updated quaternion with a
// CORDIC model of its own and checks every result; depends on qara_pkg and qara_if.
`timescale 1ns / 1ps

module quaternion_axis_rotation_accumulator_top_tb;

	localparam int unsigned CW       = qara_pkg::COMPONENT_BITS_DEF;
	localparam int unsigned AW       = qara_pkg::ANGLE_BITS_DEF;
	localparam int unsigned STEPS    = qara_pkg::CORDIC_STEPS_DEF;
	localparam int          RANDOM_ITEMS = 1400;

	// Fixed-point constants of the trigonometry, all Q.30, and the component bounds.
	localparam longint PI_FIX    = 64'sd3373259426;
	localparam longint KGAIN_FIX = 64'sd652032874;
	localparam longint ROUND_FIX = 64'sd536870912;
	localparam longint COMP_MAX  = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint COMP_MIN  = -(64'sd1 <<< (CW - 1));

	typedef struct packed {
		logic          mode;
		logic [1:0]    axis;
		logic [AW-1:0] angle;
		logic [CW-1:0] lx;
		logic [CW-1:0] ly;
		logic [CW-1:0] lz;
		logic [CW-1:0] lw;
	} rot_cmd_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic [CW-1:0] w;
		logic          sat;
	} quat_res_t;

	logic clk;
	logic arst_n = 1'b0;

	qara_cmd_if cmd_ch ();
	qara_res_if res_ch ();

	quaternion_axis_rotation_accumulator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	rot_cmd_t  pending_cmds [$];
	quat_res_t quat_expect [$];
	rot_cmd_t  on_bus;
	longint    atan_fix [32];
	longint    ori_x, ori_y, ori_z, ori_w;
	int        total_items;
	int        items_sent;
	int        results_seen;
	int        send_gap;
	int        ready_left;
	bit        choke_done;
	int        mismatches = 0;

	// Clock and the single reset pulse at the start.
	initial begin
		clk = 1'b0;
		fork
			forever #6 clk = ~clk;
			begin
				repeat (2) @(posedge clk);
				arst_n <= 1'b1;
			end
		join
	end

	task automatic note_failure(input string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Half-angle sine and cosine by rotation-mode CORDIC, both Q.30.
	function automatic void half_angle_trig(input logic [AW-1:0] ang, output longint sn,
			output longint cs);
		longint zr, xr, yr, dx, dy;
		zr = (longint'(signed'(ang)) * PI_FIX) >>> AW;
		xr = KGAIN_FIX;
		yr = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (zr >= 0) begin
				xr = xr - dx;
				yr = yr + dy;
				zr = zr - atan_fix[i];
			end else begin
				xr = xr + dx;
				yr = yr - dy;
				zr = zr + atan_fix[i];
			end
		end
		sn = yr;
		cs = xr;
	endfunction

	// Round a Q.30 product sum back to a component and clamp it.
	function automatic longint round_sat(input longint acc, inout bit clipped);
		longint r;
		r = (acc + ROUND_FIX) >>> 30;
		if (r > COMP_MAX) begin
			clipped = 1'b1;
			return COMP_MAX;
		end
		if (r < COMP_MIN) begin
			clipped = 1'b1;
			return COMP_MIN;
		end
		return r;
	endfunction

	// Apply one item to the predicted orientation and return the expected result.
	function automatic quat_res_t advance_orientation(input rot_cmd_t c);
		quat_res_t r;
		longint sn, cs, ox, oy, oz, ow;
		bit clip;
		clip = 1'b0;
		if (c.mode == qara_pkg::MODE_LOAD) begin
			ori_x = longint'(signed'(c.lx));
			ori_y = longint'(signed'(c.ly));
			ori_z = longint'(signed'(c.lz));
			ori_w = longint'(signed'(c.lw));
		end else if (c.axis != qara_pkg::AXIS_NONE) begin
			half_angle_trig(c.angle, sn, cs);
			ox = ori_x;
			oy = ori_y;
			oz = ori_z;
			ow = ori_w;
			case (c.axis)
				qara_pkg::AXIS_X: begin
					ori_x = round_sat(sn * ow + cs * ox, clip);
					ori_y = round_sat(cs * oy - sn * oz, clip);
					ori_z = round_sat(cs * oz + sn * oy, clip);
					ori_w = round_sat(cs * ow - sn * ox, clip);
				end
				qara_pkg::AXIS_Y: begin
					ori_x = round_sat(cs * ox + sn * oz, clip);
					ori_y = round_sat(sn * ow + cs * oy, clip);
					ori_z = round_sat(cs * oz - sn * ox, clip);
					ori_w = round_sat(cs * ow - sn * oy, clip);
				end
				default: begin
					ori_x = round_sat(cs * ox - sn * oy, clip);
					ori_y = round_sat(cs * oy + sn * ox, clip);
					ori_z = round_sat(sn * ow + cs * oz, clip);
					ori_w = round_sat(cs * ow - sn * oz, clip);
				end
			endcase
		end
		r.x = ori_x[CW-1:0];
		r.y = ori_y[CW-1:0];
		r.z = ori_z[CW-1:0];
		r.w = ori_w[CW-1:0];
		r.sat = clip;
		return r;
	endfunction

	function automatic logic [1:0] rand_axis();
		case ($urandom_range(0, 2))
			0:       return qara_pkg::AXIS_X;
			1:       return qara_pkg::AXIS_Y;
			default: return qara_pkg::AXIS_Z;
		endcase
	endfunction

	// A component in one of three flavors: near unit scale, anything, or max, min, zero or minus one.
	function automatic logic [CW-1:0] rand_comp(input int flavor);
		case (flavor)
			0:       return CW'(int'($urandom_range(0, 32768)) - 16384);
			1:       return CW'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       return COMP_MAX[CW-1:0];
					1:       return COMP_MIN[CW-1:0];
					2:       return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [AW-1:0] rand_angle();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return AW'($urandom);
		if (pick < 90)
			return AW'(int'($urandom_range(0, 128)) - 64);
		case ($urandom_range(0, 4))
			0:       return {1'b1, {(AW-1){1'b0}}};
			1:       return {1'b0, {(AW-1){1'b1}}};
			2:       return '0;
			3:       return AW'(1);
			default: return '1;
		endcase
	endfunction

	// Rotate items carry random load fields, which the block must ignore.
	task automatic queue_rot(input logic [1:0] ax, input logic [AW-1:0] ang);
		pending_cmds.push_back('{qara_pkg::MODE_ROTATE, ax, ang, CW'($urandom),
			CW'($urandom), CW'($urandom), CW'($urandom)});
	endtask

	// Load items carry a random axis and angle, which the block must ignore.
	task automatic queue_load(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z, input logic [CW-1:0] w);
		pending_cmds.push_back('{qara_pkg::MODE_LOAD, 2'($urandom), AW'($urandom),
			x, y, z, w});
	endtask

	// Sender gaps: mostly short, a few long, and two windows with none at all.
	function automatic int pick_gap(input int n_sent);
		int pick;
		if ((n_sent / 250) % 3 == 1)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Stimulus: directed corner items, then a random mix.
	initial begin
		int pick;
		int flavor;
		atan_fix = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001, 64'h00000000
		};
		ori_x = 0;
		ori_y = 0;
		ori_z = 0;
		ori_w = 64'sd1 <<< (CW - 2);

		// The no-rotation axis code first shows the identity left by reset.
		queue_rot(qara_pkg::AXIS_NONE, AW'($urandom));
		queue_rot(qara_pkg::AXIS_X, '0);
		queue_rot(qara_pkg::AXIS_X, AW'(16384));
		queue_rot(qara_pkg::AXIS_Y, {1'b1, {(AW-1){1'b0}}});
		queue_rot(qara_pkg::AXIS_Z, {1'b0, {(AW-1){1'b1}}});
		// Full-scale components rotated by a quarter turn must clamp.
		queue_load(COMP_MAX[CW-1:0], COMP_MAX[CW-1:0], COMP_MAX[CW-1:0], COMP_MAX[CW-1:0]);
		queue_rot(qara_pkg::AXIS_Z, AW'(16384));
		queue_load(COMP_MIN[CW-1:0], COMP_MIN[CW-1:0], COMP_MIN[CW-1:0], COMP_MIN[CW-1:0]);
		queue_rot(qara_pkg::AXIS_X, AW'(-16384));
		queue_rot(qara_pkg::AXIS_NONE, '1);
		queue_load(COMP_MIN[CW-1:0], COMP_MAX[CW-1:0], '0, '1);
		queue_rot(qara_pkg::AXIS_Y, AW'(1));
		queue_rot(qara_pkg::AXIS_Y, '1);
		queue_rot(qara_pkg::AXIS_Z, {1'b1, {(AW-1){1'b0}}});
		queue_load('0, '0, '0, CW'(16384));
		queue_rot(qara_pkg::AXIS_X, {1'b0, {(AW-1){1'b1}}});
		queue_rot(qara_pkg::AXIS_Y, {1'b0, {(AW-1){1'b1}}});
		queue_rot(qara_pkg::AXIS_Z, {1'b1, {(AW-1){1'b0}}});
		queue_rot(qara_pkg::AXIS_X, {1'b1, {(AW-1){1'b0}}});
		queue_rot(qara_pkg::AXIS_NONE, '0);

		// Mostly rotation chains, with fresh loads now and then.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 14) begin
				flavor = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
				queue_load(rand_comp(flavor), rand_comp(flavor), rand_comp(flavor),
					rand_comp(flavor));
			end else if (pick < 18) begin
				queue_rot(qara_pkg::AXIS_NONE, rand_angle());
			end else begin
				queue_rot(rand_axis(), rand_angle());
			end
		end
		total_items = pending_cmds.size();

		// Drain: every item taken, every result back, then a little quiet time.
		wait (arst_n && items_sent == total_items);
		while (quat_expect.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Overall time limit.
	initial begin
		#8000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Driver: offers queued items and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid  <= 1'b0;
			cmd_ch.mode   <= qara_pkg::MODE_LOAD;
			cmd_ch.axis   <= qara_pkg::AXIS_X;
			cmd_ch.angle  <= '0;
			cmd_ch.load_x <= '0;
			cmd_ch.load_y <= '0;
			cmd_ch.load_z <= '0;
			cmd_ch.load_w <= '0;
			send_gap      <= 0;
			items_sent    <= 0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (cmd_ch.valid) begin
				quat_expect.push_back(advance_orientation(on_bus));
				items_sent <= items_sent + 1;
			end
			if (send_gap != 0) begin
				send_gap     <= send_gap - 1;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				on_bus = pending_cmds.pop_front();
				cmd_ch.mode   <= on_bus.mode;
				cmd_ch.axis   <= on_bus.axis;
				cmd_ch.angle  <= on_bus.angle;
				cmd_ch.load_x <= on_bus.lx;
				cmd_ch.load_y <= on_bus.ly;
				cmd_ch.load_z <= on_bus.lz;
				cmd_ch.load_w <= on_bus.lw;
				cmd_ch.valid  <= 1'b1;
				send_gap      <= pick_gap(items_sent);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver ready: random stalls, two calm windows, and one long hold-off
	// so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			ready_left   <= 0;
			choke_done   <= 1'b0;
		end else if (!choke_done && results_seen >= 300) begin
			res_ch.ready <= 1'b0;
			ready_left   <= 350;
			choke_done   <= 1'b1;
		end else if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if ((results_seen / 250) % 3 == 1) begin
			res_ch.ready <= 1'b1;
		end else if (res_ch.ready) begin
			res_ch.ready <= 1'b0;
			ready_left   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
				: $urandom_range(5, 40);
		end else begin
			res_ch.ready <= 1'b1;
			ready_left   <= $urandom_range(0, 6);
		end
	end

	// Monitor: every accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : watch_results
		quat_res_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			results_seen <= results_seen + 1;
			if (quat_expect.size() == 0) begin
				note_failure("result arrived with nothing expected");
			end else begin
				want = quat_expect.pop_front();
				if (res_ch.out_x !== want.x)
					note_failure($sformatf("result %0d out_x got %0d want %0d",
						results_seen, res_ch.out_x, signed'(want.x)));
				if (res_ch.out_y !== want.y)
					note_failure($sformatf("result %0d out_y got %0d want %0d",
						results_seen, res_ch.out_y, signed'(want.y)));
				if (res_ch.out_z !== want.z)
					note_failure($sformatf("result %0d out_z got %0d want %0d",
						results_seen, res_ch.out_z, signed'(want.z)));
				if (res_ch.out_w !== want.w)
					note_failure($sformatf("result %0d out_w got %0d want %0d",
						results_seen, res_ch.out_w, signed'(want.w)));
				if (res_ch.saturated !== want.sat)
					note_failure($sformatf("result %0d saturated got %b want %b",
						results_seen, res_ch.saturated, want.sat));
			end
		end
	end

endmodule
